FILE: design/dle_pkg.sv
// ----------------------------------------------------------------------------
// DNS label encoder package
// Shared constants, state codes and the structs that pass between the front
// end, the label queue and the emitter.
// ----------------------------------------------------------------------------
package dle_pkg;

	localparam int CHAR_W = 8;
	// A label count is a six-bit quantity, so the label storage never needs
	// more than seven address bits for its two banks.
	localparam int LEN_W  = 6;
	localparam int ADDR_W = LEN_W + 1;

	localparam logic [CHAR_W-1:0] DOT_CHAR = 8'd46;
	localparam logic [CHAR_W-1:0] END_CHAR = 8'd0;

	typedef logic [CHAR_W-1:0] char_t;

	// One finished label waiting to be emitted.
	typedef struct packed {
		logic             bank;
		logic [LEN_W-1:0] cnt;
		logic             is_end;
	} cmd_t;

	// Write port into the label storage.
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		char_t             data;
	} wr_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LEN,
		BK_RD,
		BK_CHR,
		BK_ZERO
	} bk_state_t;

endpackage

FILE: design/dns_label_encoder.sv
// ----------------------------------------------------------------------------
// DNS label encoder
// Turns a dotted domain name into the length-prefixed label form of DNS.
// ----------------------------------------------------------------------------
// The slave channel takes one name character per item; a dot closes a label
// and a zero byte closes the name. The master channel gives the encoded bytes:
// for every label a length byte followed by its characters, and after the
// last label of a name a single zero byte. tlast marks the final byte of the
// run that one dot or one zero byte releases.
// Plain characters are taken in one cycle each and give no output. Characters
// past MAX_LABEL in one label are discarded, so the label is sent truncated.
// A closed label is queued; for the length byte the emitter takes up the
// queued label in BK_IDLE, then loads the output register in BK_LEN; for
// each character it reads the storage in BK_RD, then loads the output
// register in BK_CHR; the closing zero is loaded in BK_ZERO. The label
// storage has two banks and the queue two entries, so the next label is
// collected while the previous one drains; input stalls only while two
// closed labels are queued, the one being sent included.
// Reset clears the queue, the emitter and the character count; the label
// storage itself is not cleared. A stall on the master side holds the output
// register, and the input side keeps running until both banks are taken.
// ----------------------------------------------------------------------------
module dns_label_encoder #(
	parameter int MAX_LABEL = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	// Input items.
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_char
	// Encoded output items.
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tlast
);

	// Handshake between the front end and the label queue.
	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_nonempty;
	dle_pkg::cmd_t q_cmd;
	dle_pkg::cmd_t q_head;
	dle_pkg::wr_t  wr;

	dle_front #(
		.MAX_LABEL(MAX_LABEL)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (q_cmd),
		.wr           (wr)
	);

	dle_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(q_cmd),
		.pop     (q_pop),
		.head    (q_head),
		.nonempty(q_nonempty),
		.full    (q_full)
	);

	// The emitter owns the label storage; the front end writes it through wr.
	dle_emit #(
		.MAX_LABEL(MAX_LABEL)
	) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr           (wr),
		.cmd          (q_head),
		.cmd_valid    (q_nonempty),
		.cmd_pop      (q_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

FILE: design/dle_front.sv
// ----------------------------------------------------------------------------
// DNS label encoder front end
// Accepts name characters, writes label characters into the current bank and
// queues a finished label whenever a dot or the end of the name arrives.
// ----------------------------------------------------------------------------
module dle_front #(
	parameter int MAX_LABEL = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  dle_pkg::char_t s_axis_tdata,
	input  logic          q_full,
	output logic          q_push,
	output dle_pkg::cmd_t q_cmd,
	output dle_pkg::wr_t  wr
);

	logic [dle_pkg::LEN_W-1:0] count_q;
	logic                      bank_q;
	logic                      accept;
	logic                      delim;
	logic                      room;

	// Ready only while the bank being filled is not owned by a queued label.
	assign s_axis_tready = !q_full;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign delim  = (s_axis_tdata == dle_pkg::DOT_CHAR) || (s_axis_tdata == dle_pkg::END_CHAR);
	assign room   = count_q < dle_pkg::LEN_W'(MAX_LABEL);

	assign q_push       = accept && delim;
	assign q_cmd.bank   = bank_q;
	assign q_cmd.cnt    = count_q;
	assign q_cmd.is_end = (s_axis_tdata == dle_pkg::END_CHAR);

	assign wr.en   = accept && !delim && room;
	assign wr.addr = {1'b0, count_q} + (bank_q ? dle_pkg::ADDR_W'(MAX_LABEL) : '0);
	assign wr.data = s_axis_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bank_q  <= 1'b0;
		end else if (q_push) begin
			count_q <= '0;
			bank_q  <= !bank_q;
		end else if (wr.en) begin
			count_q <= count_q + 1'b1;
		end
	end

endmodule

FILE: design/dle_cmd_fifo.sv
// ----------------------------------------------------------------------------
// DNS label encoder label queue
// Two-entry queue of finished labels. An entry stays until its last byte
// is loaded for output, so it also marks its storage bank as busy.
// ----------------------------------------------------------------------------
module dle_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dle_pkg::cmd_t push_cmd,
	input  logic          pop,
	output dle_pkg::cmd_t head,
	output logic          nonempty,
	output logic          full
);

	dle_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;

	assign head     = entry_q[rd_ptr_q];
	assign nonempty = (fill_q != 2'd0);
	assign full     = (fill_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: design/dle_emit.sv
// ----------------------------------------------------------------------------
// DNS label encoder emitter
// Holds the two-bank label storage and sends each queued label as a length
// byte, its characters and, at the end of a name, a closing zero byte.
// ----------------------------------------------------------------------------
module dle_emit #(
	parameter int MAX_LABEL = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  dle_pkg::wr_t   wr,
	input  dle_pkg::cmd_t  cmd,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output dle_pkg::char_t m_axis_tdata,
	output logic           m_axis_tlast
);

	localparam int DEPTH = 2 * MAX_LABEL;
	localparam int AW    = $clog2(DEPTH);

	dle_pkg::char_t mem [DEPTH];
	dle_pkg::char_t rd_data_q;

	dle_pkg::bk_state_t state_q, state_nx;

	logic [dle_pkg::LEN_W-1:0]  idx_q;
	logic [dle_pkg::ADDR_W-1:0] rd_addr;
	logic                       slot_free;
	logic                       last_chr;
	logic                       rd_en;
	logic                       load_out;
	logic                       idx_clr;
	logic                       idx_inc;
	dle_pkg::char_t             out_data_nx;
	logic                       out_last_nx;

	logic           out_valid_q;
	dle_pkg::char_t out_data_q;
	logic           out_last_q;

	assign slot_free = !out_valid_q || m_axis_tready;
	assign last_chr  = (idx_q == cmd.cnt - 1'b1);
	assign rd_addr   = {1'b0, idx_q} + (cmd.bank ? dle_pkg::ADDR_W'(MAX_LABEL) : '0);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr[AW-1:0]];
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			dle_pkg::BK_IDLE: begin
				if (cmd_valid) state_nx = dle_pkg::BK_LEN;
			end
			dle_pkg::BK_LEN: begin
				if (slot_free) begin
					if (cmd.cnt != '0)   state_nx = dle_pkg::BK_RD;
					else if (cmd.is_end) state_nx = dle_pkg::BK_ZERO;
					else                 state_nx = dle_pkg::BK_IDLE;
				end
			end
			dle_pkg::BK_RD: begin
				state_nx = dle_pkg::BK_CHR;
			end
			dle_pkg::BK_CHR: begin
				if (slot_free) begin
					if (!last_chr)       state_nx = dle_pkg::BK_RD;
					else if (cmd.is_end) state_nx = dle_pkg::BK_ZERO;
					else                 state_nx = dle_pkg::BK_IDLE;
				end
			end
			dle_pkg::BK_ZERO: begin
				if (slot_free) state_nx = dle_pkg::BK_IDLE;
			end
			default: state_nx = dle_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		rd_en       = 1'b0;
		load_out    = 1'b0;
		idx_clr     = 1'b0;
		idx_inc     = 1'b0;
		cmd_pop     = 1'b0;
		out_data_nx = dle_pkg::END_CHAR;
		out_last_nx = 1'b0;
		case (state_q)
			dle_pkg::BK_IDLE: begin
				idx_clr = 1'b1;
			end
			dle_pkg::BK_LEN: begin
				load_out    = slot_free;
				out_data_nx = dle_pkg::char_t'(cmd.cnt);
				out_last_nx = (cmd.cnt == '0) && !cmd.is_end;
				cmd_pop     = slot_free && out_last_nx;
			end
			dle_pkg::BK_RD: begin
				rd_en = 1'b1;
			end
			dle_pkg::BK_CHR: begin
				load_out    = slot_free;
				out_data_nx = rd_data_q;
				out_last_nx = last_chr && !cmd.is_end;
				idx_inc     = slot_free;
				cmd_pop     = slot_free && out_last_nx;
			end
			dle_pkg::BK_ZERO: begin
				load_out    = slot_free;
				out_data_nx = dle_pkg::END_CHAR;
				out_last_nx = 1'b1;
				cmd_pop     = slot_free;
			end
			default: begin
				idx_clr = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dle_pkg::BK_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= out_data_nx;
			out_last_q <= out_last_nx;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

FILE: design/dle_checker.sv
// ----------------------------------------------------------------------------
// DNS label encoder checker
// Port-level checks on the encoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module dle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);

	// A stalled output item keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output item changed while stalled");

	// The byte closing a run is a character, an empty length or the final
	// zero, and never a dot.
	a_last_no_dot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata != dle_pkg::DOT_CHAR)
		else $error("run closed by a dot byte");

	// Nothing is offered straight after reset.
	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("output valid right after reset");

	// A waiting input item is held until the encoder takes it.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
		s_axis_tvalid && $stable(s_axis_tdata))
		else $error("input item changed while waiting");

endmodule

bind dns_label_encoder dle_checker u_dle_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);

FILE: tb/tb_dns_label_encoder.sv
// ----------------------------------------------------------------------------
// DNS label encoder testbench
// Streams domain names into the encoder one character per item and checks
// every encoded byte and its tlast flag against a predictor of the label
// encoding. Names are sent in three phases with different idling on the input
// and output channels, and the input pauses between phases until every
// predicted byte has arrived.
// ----------------------------------------------------------------------------
module tb_dns_label_encoder;

	localparam int MAX_LABEL    = 32;
	// Each phase ends once the running item count reaches its share of about
	// a hundred items.
	localparam int PHASE_ITEMS  = 33;
	localparam int SETTLE_TICKS = 120;

	// One encoded byte as it should leave the master channel.
	typedef struct {
		dle_pkg::char_t value;
		logic           last;
	} enc_byte_t;

	logic           clk           = 1'b0;
	logic           arst_n        = 1'b0;
	logic           s_axis_tvalid = 1'b0;
	logic           s_axis_tready;
	dle_pkg::char_t s_axis_tdata  = '0;
	logic           m_axis_tvalid;
	logic           m_axis_tready = 1'b0;
	dle_pkg::char_t m_axis_tdata;
	logic           m_axis_tlast;

	// Predictor state: the label being collected.
	dle_pkg::char_t label_buf [MAX_LABEL];
	int             label_len     = 0;
	bit             label_dropped = 1'b0;

	enc_byte_t      encoded_q [$];    // bytes still owed by the encoder, oldest first
	dle_pkg::char_t name_chars_q [$]; // characters waiting to be sent
	enc_byte_t      want_byte;
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;
	int             queued_items  = 0;
	int             errors        = 0;

	dns_label_encoder #(
		.MAX_LABEL(MAX_LABEL)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Works out the bytes that one accepted character releases. A dot closes
	// the label, a zero byte closes the label and then the name; any other
	// value is buffered, or dropped once the label is full.
	function automatic void encode_char(input dle_pkg::char_t c);
		enc_byte_t b;
		bit        closes_name;
		closes_name = (c == dle_pkg::END_CHAR);
		if (c == dle_pkg::DOT_CHAR || c == dle_pkg::END_CHAR) begin
			b.value = dle_pkg::char_t'(label_len);
			b.last  = !closes_name && label_len == 0;
			encoded_q.push_back(b);
			for (int i = 0; i < label_len; i++) begin
				b.value = label_buf[i];
				b.last  = !closes_name && i == label_len - 1;
				encoded_q.push_back(b);
			end
			if (closes_name) begin
				b.value = dle_pkg::END_CHAR;
				b.last  = 1'b1;
				encoded_q.push_back(b);
				label_dropped = 1'b0;
			end
			label_len = 0;
		end else if (label_len < MAX_LABEL) begin
			label_buf[label_len] = c;
			label_len++;
		end else begin
			label_dropped = 1'b1;
		end
	endfunction

	task automatic queue_char(input dle_pkg::char_t c);
		name_chars_q.push_back(c);
		queued_items++;
	endtask

	// A label of random characters, never a delimiter.
	task automatic queue_label(input int len);
		dle_pkg::char_t c;
		for (int i = 0; i < len; i++) begin
			do
				c = dle_pkg::char_t'($urandom_range(1, 255));
			while (c == dle_pkg::DOT_CHAR);
			queue_char(c);
		end
	endtask

	// A well-formed name of random labels, sometimes with a trailing dot and
	// sometimes followed by a burst of arbitrary bytes.
	task automatic queue_name(input bit force_long);
		int n_labels;
		int len;
		n_labels = $urandom_range(1, 4);
		for (int l = 0; l < n_labels; l++) begin
			if (force_long && l == 0)
				len = $urandom_range(MAX_LABEL + 1, MAX_LABEL + 4);
			else if ($urandom_range(19) == 0)
				len = $urandom_range(MAX_LABEL - 2, MAX_LABEL + 3);
			else
				len = $urandom_range(0, 6);
			queue_label(len);
			if (l != n_labels - 1 || $urandom_range(4) == 0)
				queue_char(dle_pkg::DOT_CHAR);
		end
		queue_char(dle_pkg::END_CHAR);
		if ($urandom_range(7) == 0) begin
			len = $urandom_range(1, 4);
			for (int i = 0; i < len; i++)
				queue_char(dle_pkg::char_t'($urandom_range(0, 255)));
		end
	endtask

	// Input side: offers the next character whenever the channel is free,
	// idling at random, and predicts the output of each accepted item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				encode_char(s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (name_chars_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= name_chars_q.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output side: stalls at random and checks every accepted byte against
	// the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (encoded_q.size() == 0) begin
					$display("%0t: unexpected byte: expected none, actual %h last %b",
						$time, m_axis_tdata, m_axis_tlast);
					errors++;
				end else begin
					want_byte = encoded_q.pop_front();
					if (m_axis_tdata !== want_byte.value) begin
						$display("%0t: out_byte mismatch: expected %h, actual %h",
							$time, want_byte.value, m_axis_tdata);
						errors++;
					end
					if (m_axis_tlast !== want_byte.last) begin
						$display("%0t: tlast mismatch: expected %b, actual %b",
							$time, want_byte.last, m_axis_tlast);
						errors++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		dle_pkg::char_t directed_chars [$];
		int             phase_target;
		// Empty name; an empty label; a label with the extreme characters;
		// characters either side of the dot and the top bit; two empty labels
		// in a row; a single-character label.
		directed_chars = '{dle_pkg::END_CHAR,
			dle_pkg::DOT_CHAR, dle_pkg::END_CHAR,
			8'h01, 8'hFF, dle_pkg::DOT_CHAR,
			8'h2D, 8'h2F, 8'h80, 8'h7F, dle_pkg::END_CHAR,
			dle_pkg::DOT_CHAR, dle_pkg::DOT_CHAR, dle_pkg::END_CHAR,
			8'h61, dle_pkg::END_CHAR};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < 3; phase++) begin
			@(negedge clk);
			case (phase)
				0: begin
					send_idle_pct = 27;
					recv_idle_pct = 85;
				end
				1: begin
					send_idle_pct = 85;
					recv_idle_pct = 27;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (phase == 0) begin
				foreach (directed_chars[i])
					queue_char(directed_chars[i]);
			end
			phase_target = (phase + 1) * PHASE_ITEMS;
			// The first random name of the first phase always carries an over-long label.
			queue_name(phase == 0);
			while (queued_items < phase_target)
				queue_name(1'b0);
			// Hold the input back until the whole phase has drained.
			while (name_chars_q.size() != 0 || s_axis_tvalid)
				@(negedge clk);
			while (encoded_q.size() != 0)
				@(negedge clk);
		end

		// Catch any stray byte that the encoder might still send.
		repeat (SETTLE_TICKS) @(negedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: dns_label_encoder.f
design/dle_pkg.sv
design/dle_front.sv
design/dle_cmd_fifo.sv
design/dle_emit.sv
design/dns_label_encoder.sv
design/dle_checker.sv
tb/tb_dns_label_encoder.sv
